@@ sv/unicode_to_single_byte_charset_top_assert.svh @@
// assertion macros for the charset encoder
`ifndef UNICODE_TO_SINGLE_BYTE_CHARSET_TOP_ASSERT_SVH
`define UNICODE_TO_SINGLE_BYTE_CHARSET_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define U2SB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("u2sb assertion failed");

`define U2SB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u2sb assertion failed");

`else

`define U2SB_ASSERT(lbl, prop)

`define U2SB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/u2sb_pkg.sv @@
package u2sb_pkg;

    typedef enum logic [2:0] {
        CS_8859_1  = 3'd0,
        CS_8859_5  = 3'd1,
        CS_8859_6  = 3'd2,
        CS_8859_7  = 3'd3,
        CS_8859_8  = 3'd4,
        CS_8859_9  = 3'd5,
        CS_8859_15 = 3'd6,
        CS_TIS620  = 3'd7
    } t_charset;

    localparam int unsigned CpW   = 21;
    localparam int unsigned CodeW = 7;

    typedef logic [CpW-1:0]   t_cp;
    typedef logic [CodeW-1:0] t_code;

    localparam t_cp   NumeroSign = 21'h2116;
    localparam t_cp   EuroSign   = 21'h20AC;
    localparam t_code ThaiOffset = 7'h60;
    localparam t_code GreekOffs  = 7'h50;
    localparam t_code HebrewOffs = 7'h70;
    localparam t_code NbspCode   = 7'h20;

endpackage

@@ sv/unicode_to_single_byte_charset_top.sv @@
// unicode to single-byte charset encoder, right half with msb cleared
//
// input channel: i_in_valid / o_in_stall carry one code point per item on
// i_code_point. an item is taken at a clock edge with valid high and stall low.
// output channel: o_out_valid / i_out_stall carry o_mapped and o_byte_code.
// o_byte_code is 0 when the point has no code in the selected charset.
// i_cfg_wr_en / i_cfg_wr_data write the 3-bit charset select; write it only
// while no item is in flight.
// a result passes the input register, range compare stage and output register
// before o_out_valid rises. throughput: one item per cycle while the
// receiver does not stall.
// reset (i_rst_n low at a clock edge) empties all stages and selects 8859-1.
// when the receiver stalls the output holds; bubbles ahead of it still close,
// and o_in_stall rises only once all three stages hold items.
`include "unicode_to_single_byte_charset_top_assert.svh"

module unicode_to_single_byte_charset_top
    import u2sb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [2:0]       i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [CpW-1:0]   i_code_point,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_mapped,
    output logic [CodeW-1:0] o_byte_code
);

    t_charset r_charset;

    logic  r1_valid;
    t_cp   r1_cp;
    logic  r2_valid;
    logic  r2_spec_hit;
    t_code r2_spec_code;
    logic  r2_fb_hit;
    t_code r2_fb_code;
    logic  r3_valid;
    logic  r3_mapped;
    t_code r3_code;

    logic  en1;
    logic  en2;
    logic  en3;
    logic  n_spec_hit;
    t_code n_spec_code;
    logic  n_fb_hit;
    logic  n_mapped;
    t_code n_code;

    assign en3 = !r3_valid || !i_out_stall;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charset <= CS_8859_1;
        end else if (i_cfg_wr_en) begin
            r_charset <= t_charset'(i_cfg_wr_data);
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r1_cp <= i_code_point;
        end
    end

    // stage 2: charset specific points and ranges
    always_comb begin
        n_spec_hit  = 1'b0;
        n_spec_code = '0;
        case (r_charset)
            CS_8859_5: begin
                if (r1_cp == NumeroSign) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = 7'h70;
                end else if (r1_cp inside {[21'h401:21'h40C], [21'h40E:21'h44F],
                                           [21'h451:21'h45C], [21'h45E:21'h45F]}) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = r1_cp[6:0] + 7'h20;
                end
            end
            CS_8859_6: begin
                if (r1_cp == 21'h60C) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = 7'h2C;
                end else if (r1_cp inside {[21'h61B:21'h652]}) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = r1_cp[6:0] + 7'h20;
                end
            end
            CS_8859_7: begin
                if (r1_cp == 21'h2015) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = 7'h2F;
                end else if (r1_cp inside {[21'h2018:21'h2019]}) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = 7'h21 + {6'd0, r1_cp[0]};
                end else if (r1_cp inside {[21'h384:21'h386], [21'h388:21'h38A],
                                           21'h38C, [21'h38E:21'h3CE]}) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = r1_cp[6:0] - GreekOffs;
                end
            end
            CS_8859_8: begin
                if (r1_cp == 21'h2017) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = 7'h5F;
                end else if (r1_cp inside {[21'h5D0:21'h5EA]}) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = r1_cp[6:0] - HebrewOffs;
                end else if (r1_cp inside {[21'h200E:21'h200F]}) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = 7'h7D + {6'd0, r1_cp[0]};
                end
            end
            CS_8859_9: begin
                n_spec_hit = 1'b1;
                case (r1_cp)
                    21'h11E: n_spec_code = 7'h50;
                    21'h130: n_spec_code = 7'h5D;
                    21'h15E: n_spec_code = 7'h5E;
                    21'h11F: n_spec_code = 7'h70;
                    21'h131: n_spec_code = 7'h7D;
                    21'h15F: n_spec_code = 7'h7E;
                    default: n_spec_hit  = 1'b0;
                endcase
            end
            CS_8859_15: begin
                n_spec_hit = 1'b1;
                case (r1_cp)
                    EuroSign: n_spec_code = 7'h24;
                    21'h160:  n_spec_code = 7'h26;
                    21'h161:  n_spec_code = 7'h28;
                    21'h17D:  n_spec_code = 7'h34;
                    21'h17E:  n_spec_code = 7'h38;
                    21'h152:  n_spec_code = 7'h3C;
                    21'h153:  n_spec_code = 7'h3D;
                    21'h178:  n_spec_code = 7'h3E;
                    default:  n_spec_hit  = 1'b0;
                endcase
            end
            CS_TIS620: begin
                if (r1_cp == 21'hA0) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = NbspCode;
                end else if (r1_cp inside {[21'hE01:21'hE5F]}) begin
                    n_spec_hit  = 1'b1;
                    n_spec_code = r1_cp[6:0] - ThaiOffset;
                end
            end
            default: begin
                n_spec_hit  = 1'b0;
                n_spec_code = '0;
            end
        endcase
    end

    // latin-1 fallback, not for tis-620
    assign n_fb_hit = (r_charset != CS_TIS620) && (r1_cp inside {[21'hA0:21'hFF]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r2_spec_hit  <= n_spec_hit;
            r2_spec_code <= n_spec_code;
            r2_fb_hit    <= n_fb_hit;
            r2_fb_code   <= r1_cp[6:0];
        end
    end

    // stage 3: pick special code, else fallback, else zero
    assign n_mapped = r2_spec_hit || r2_fb_hit;
    assign n_code   = r2_spec_hit ? r2_spec_code :
                      r2_fb_hit   ? r2_fb_code   : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_valid) begin
            r3_mapped <= n_mapped;
            r3_code   <= n_code;
        end
    end

    assign o_out_valid = r3_valid;
    assign o_mapped    = r3_mapped;
    assign o_byte_code = r3_code;

    `U2SB_ASSERT(a_unmapped_zero, (r3_valid && !r3_mapped) |-> (r3_code == '0))
    `U2SB_ASSERT_NEXT(a_accept_lands, (i_in_valid && !o_in_stall), r1_valid)
    `U2SB_ASSERT(a_stall_full, o_in_stall |-> (r1_valid && r2_valid && r3_valid && i_out_stall))

endmodule
